// ----- rtl/circular_queue_with_dump_top_assert.svh -----
// ----------------------------------------------------------------------------
// Circular queue assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_DUMP_TOP_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_DUMP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property checked on every edge outside reset
`define CQD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication checked on every edge outside reset
`define CQD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CQD_ASSERT(label, clk, rst_n, prop, msg)
`define CQD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/cqd_pkg.sv -----
// ----------------------------------------------------------------------------
// Circular queue package
// Sizes, command and status codes, and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cqd_pkg;

    // storage geometry
    localparam int unsigned DEPTH  = 64;
    localparam int unsigned IDX_W  = $clog2(DEPTH);
    localparam int unsigned SIZE_W = 7;
    localparam int unsigned DATA_W = 32;

    // request kinds
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_DELETE = 2'd1;
    localparam t_cmd CMD_DUMP   = 2'd2;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic idle;        // may take a request or a size write
        logic capture;     // latch the incoming request
        logic insert;      // append or report full
        logic empty_rsp;   // emit an empty status
        logic start_read;  // read the head slot, start the walk
        logic next_read;   // read the walk slot
        logic emit;        // load read data into the output register
        logic pop;         // remove the head word
        logic step;        // advance the walk pointer
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic out_free;
        logic walk_last;
    } t_dp_stat;

endpackage

// ----- rtl/circular_queue_with_dump_top.sv -----
// ----------------------------------------------------------------------------
// Circular queue with dump, top level
// Channel      | dir | handshake              | payload
// s_axis       | in  | s_axis_tvalid/tready   | tdata: write_value, tuser: cmd
// m_axis       | out | m_axis_tvalid/tready   | tdata: read_value, tuser: status,
//              |     |                        | tlast: last
// cfg          | in  | i_cfg_valid/o_cfg_ready| i_cfg_data: queue_size
//
// Delete and dump answer an empty queue with an empty status; otherwise a dump
// reads the stored words one at a time through the single slot memory read
// port with registered data. Result stalls hold the sequence.
// A result waits in the output register; the next request is taken meanwhile.
// Reset (synchronous) empties the queue and sets the size to 64; slot contents
// stay undefined and are never read before being written.
// ----------------------------------------------------------------------------
module circular_queue_with_dump_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // [31:0] write_value
    input  logic [1:0]                  s_axis_tuser,   // [1:0] cmd
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,   // [31:0] read_value
    output logic [1:0]                  m_axis_tuser,   // [1:0] status
    output logic                        m_axis_tlast,
    // size register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cqd_pkg::SIZE_W-1:0]  i_cfg_data
);

    cqd_pkg::t_dp_cmd  dp_cmd;
    cqd_pkg::t_dp_stat dp_stat;

    assign s_axis_tready = dp_cmd.idle;
    assign o_cfg_ready   = dp_cmd.idle;

    // sequencer
    cqd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // storage and result path
    cqd_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_req_cmd    (s_axis_tuser),
        .i_req_data   (s_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (m_axis_tuser),
        .o_out_data   (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule

// ----- rtl/cqd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Circular queue controller
// Sequences insert, delete and dump requests over the datapath.
// ----------------------------------------------------------------------------
module cqd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  cqd_pkg::t_dp_stat  i_stat,
    output cqd_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_EMIT = 4'b0100,
        S_NEXT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.cmd)
                    cqd_pkg::CMD_INSERT: begin
                        if (i_stat.out_free) begin
                            o_cmd.insert = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    cqd_pkg::CMD_DELETE, cqd_pkg::CMD_DUMP: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.empty_rsp = 1'b1;
                                n_state         = S_IDLE;
                            end
                        end else begin
                            o_cmd.start_read = 1'b1;
                            n_state          = S_EMIT;
                        end
                    end
                    default: n_state = S_IDLE;  // unused code: no result
                endcase
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.cmd == cqd_pkg::CMD_DELETE) begin
                        o_cmd.pop = 1'b1;
                        n_state   = S_IDLE;
                    end else if (i_stat.walk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                o_cmd.next_read = 1'b1;
                n_state         = S_EMIT;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/cqd_datapath.sv -----
// ----------------------------------------------------------------------------
// Circular queue datapath
// Slot memory, head/tail/walk pointers, size register and result register.
// ----------------------------------------------------------------------------
`include "circular_queue_with_dump_top_assert.svh"

module cqd_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cqd_pkg::t_dp_cmd                 i_cmd,
    output cqd_pkg::t_dp_stat                o_stat,
    input  cqd_pkg::t_cmd                    i_req_cmd,
    input  logic [cqd_pkg::DATA_W-1:0]       i_req_data,
    input  logic                             i_cfg_valid,
    input  logic [cqd_pkg::SIZE_W-1:0]       i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output cqd_pkg::t_status                 o_out_status,
    output logic [cqd_pkg::DATA_W-1:0]       o_out_data,
    output logic                             o_out_last
);

    localparam int unsigned IDX_W  = cqd_pkg::IDX_W;
    localparam int unsigned SIZE_W = cqd_pkg::SIZE_W;
    localparam int unsigned DATA_W = cqd_pkg::DATA_W;

    logic [DATA_W-1:0]  mem [cqd_pkg::DEPTH];

    cqd_pkg::t_cmd      r_cmd;
    logic [DATA_W-1:0]  r_wdata;
    logic [SIZE_W-1:0]  r_size, n_size;
    logic [IDX_W-1:0]   r_head, r_tail, r_ptr, r_cnt;
    logic               r_empty;
    logic [DATA_W-1:0]  r_rd_data;
    logic               r_out_valid;
    cqd_pkg::t_status   r_out_status;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_last;

    logic [IDX_W-1:0]   tail_nx, head_nx, ptr_nx, wr_addr, rd_addr;
    logic               full, out_free, walk_last, cfg_we, wr_en, rd_en, load;

    // next index with wrap at the active size
    function automatic logic [IDX_W-1:0] f_adv(input logic [IDX_W-1:0] idx,
                                              input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] nx;
        nx = SIZE_W'(idx) + SIZE_W'(1);
        return (nx >= sz) ? '0 : nx[IDX_W-1:0];
    endfunction

    assign tail_nx   = f_adv(r_tail, r_size);
    assign head_nx   = f_adv(r_head, r_size);
    assign ptr_nx    = f_adv(r_ptr, r_size);
    assign full      = (tail_nx == r_head);
    assign out_free  = !r_out_valid || i_out_ready;
    assign walk_last = (r_ptr == r_tail) || (r_cnt == IDX_W'(cqd_pkg::DEPTH - 1));
    assign cfg_we    = i_cfg_valid && i_cmd.idle;

    assign o_stat.cmd       = r_cmd;
    assign o_stat.empty     = r_empty;
    assign o_stat.out_free  = out_free;
    assign o_stat.walk_last = walk_last;

    // size register clamped to 1..DEPTH
    always_comb begin
        if (i_cfg_data == '0) begin
            n_size = SIZE_W'(1);
        end else if (i_cfg_data > SIZE_W'(cqd_pkg::DEPTH)) begin
            n_size = SIZE_W'(cqd_pkg::DEPTH);
        end else begin
            n_size = i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_req_cmd;
            r_wdata <= i_req_data;
        end
    end

    // queue pointers and size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_W'(cqd_pkg::DEPTH);
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else if (cfg_we) begin
            r_size  <= n_size;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.insert) begin
            if (r_empty) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_empty <= 1'b0;
            end else if (!full) begin
                r_tail <= tail_nx;
            end
        end else if (i_cmd.pop) begin
            if (r_head == r_tail) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_empty <= 1'b1;
            end else begin
                r_head <= head_nx;
            end
        end
    end

    // dump walk pointer and word count
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_read) begin
            r_ptr <= r_head;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_ptr <= ptr_nx;
            r_cnt <= r_cnt + IDX_W'(1);
        end
    end

    // slot memory, one write and one registered read
    assign wr_en   = i_cmd.insert && (r_empty || !full);
    assign wr_addr = r_empty ? '0 : tail_nx;
    assign rd_en   = i_cmd.start_read || i_cmd.next_read;
    assign rd_addr = i_cmd.start_read ? r_head : r_ptr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // result register
    assign load = i_cmd.insert || i_cmd.empty_rsp || i_cmd.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_out_status <= (!r_empty && full) ? cqd_pkg::ST_FULL : cqd_pkg::ST_OK;
            r_out_data   <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.empty_rsp) begin
            r_out_status <= cqd_pkg::ST_EMPTY;
            r_out_data   <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_status <= cqd_pkg::ST_OK;
            r_out_data   <= r_rd_data;
            r_out_last   <= (r_cmd == cqd_pkg::CMD_DELETE) || walk_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;
    assign o_out_last   = r_out_last;

    // checks
    `CQD_ASSERT(a_idx_in_range, i_clk, i_rst_n, (SIZE_W'(r_head) < r_size) && (SIZE_W'(r_tail) < r_size), "head or tail at or beyond queue size")
    `CQD_ASSERT_IMP(a_empty_idx, i_clk, i_rst_n, r_empty, (r_head == '0) && (r_tail == '0), "empty queue with non-zero indices")
    `CQD_ASSERT_IMP(a_load_free, i_clk, i_rst_n, load, out_free, "result register overwritten while held")
    `CQD_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop || i_cmd.start_read, !r_empty, "read of an empty queue")

endmodule

// ----- tb/sv/tb_circular_queue_with_dump_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circular queue with dump, block-level testbench
// Feeds insert, delete, dump and unused requests over the request stream and
// checks every result word against a behavioural queue kept in step with the
// block. A directed table covers reset state, the extreme words, full and
// empty reports and the size extremes. Random phases follow, each under a
// fresh queue size, with random gaps on the request side and random stalls
// on the result side.
// ----------------------------------------------------------------------------
module tb_circular_queue_with_dump_top;

    localparam cqd_pkg::t_cmd CMD_UNUSED = 2'd3;   // no result, no state change
    localparam int   SETTLE_CYCLES = 8;      // block quiet after last result
    localparam int   RANDOM_ITEMS  = 320;

    // one result word as the checker sees it
    typedef struct packed {
        cqd_pkg::t_status status;
        logic [31:0]      word;
        logic             last;
    } t_result;

    // one line of the directed table
    typedef struct {
        logic                         is_cfg;
        logic [cqd_pkg::SIZE_W-1:0]   size;
        cqd_pkg::t_cmd                cmd;
        logic [31:0]                  word;
        logic                         typed;    // expectation given in the table
        cqd_pkg::t_status             status;
        logic [31:0]                  value;
    } t_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [31:0]                s_axis_tdata;   // [31:0] write_value
    logic [1:0]                 s_axis_tuser;   // [1:0] cmd
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [31:0]                m_axis_tdata;   // [31:0] read_value
    logic [1:0]                 m_axis_tuser;   // [1:0] status
    logic                       m_axis_tlast;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [cqd_pkg::SIZE_W-1:0] i_cfg_data;

    // behavioural queue
    logic [31:0]                slots [cqd_pkg::DEPTH];
    int unsigned                head_idx;
    int unsigned                tail_idx;
    logic                       queue_empty;
    logic [cqd_pkg::SIZE_W-1:0] size_reg;

    t_result awaited [$];   // results still to come, oldest first
    t_result fresh [$];     // results of the request just taken
    t_row    plan [$];
    int      errors;
    logic    sender_burst;
    logic    receiver_burst;
    int      random_count;

    circular_queue_with_dump_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- model

    // low bits of a size value as written to the register
    function automatic logic [cqd_pkg::SIZE_W-1:0] to_size(int unsigned v);
        return v[cqd_pkg::SIZE_W-1:0];
    endfunction

    // size register clamped to 1..DEPTH
    function automatic int unsigned span();
        if (size_reg == 0) return 1;
        if (size_reg > cqd_pkg::DEPTH) return cqd_pkg::DEPTH;
        return size_reg;
    endfunction

    function automatic int unsigned wrap_next(int unsigned idx);
        return (idx + 1 >= span()) ? 0 : idx + 1;
    endfunction

    function automatic void clear_queue();
        head_idx    = 0;
        tail_idx    = 0;
        queue_empty = 1'b1;
    endfunction

    function automatic void set_size(logic [cqd_pkg::SIZE_W-1:0] size);
        size_reg = size;
        clear_queue();
    endfunction

    function automatic void add_result(cqd_pkg::t_status st, logic [31:0] w, logic lst);
        t_result r;
        r.status = st;
        r.word   = w;
        r.last   = lst;
        fresh.push_back(r);
    endfunction

    // apply one request; its results land in fresh
    function automatic void queue_request(cqd_pkg::t_cmd cmd, logic [31:0] w);
        int unsigned nt;
        int unsigned idx;
        int          k;
        logic        fin;
        fresh.delete();
        case (cmd)
            cqd_pkg::CMD_INSERT: begin
                if (queue_empty) begin
                    head_idx    = 0;
                    tail_idx    = 0;
                    queue_empty = 1'b0;
                    slots[0]    = w;
                    add_result(cqd_pkg::ST_OK, '0, 1'b1);
                end else begin
                    nt = wrap_next(tail_idx);
                    if (nt == head_idx) begin
                        add_result(cqd_pkg::ST_FULL, '0, 1'b1);
                    end else begin
                        tail_idx        = nt;
                        slots[tail_idx] = w;
                        add_result(cqd_pkg::ST_OK, '0, 1'b1);
                    end
                end
            end
            cqd_pkg::CMD_DELETE: begin
                if (queue_empty) begin
                    add_result(cqd_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    add_result(cqd_pkg::ST_OK, slots[head_idx], 1'b1);
                    if (head_idx == tail_idx) clear_queue();
                    else head_idx = wrap_next(head_idx);
                end
            end
            cqd_pkg::CMD_DUMP: begin
                if (queue_empty) begin
                    add_result(cqd_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    idx = head_idx;
                    for (k = 0; k < cqd_pkg::DEPTH; k++) begin
                        fin = (idx == tail_idx) || (k == cqd_pkg::DEPTH - 1);
                        add_result(cqd_pkg::ST_OK, slots[idx], fin);
                        if (fin) break;
                        idx = wrap_next(idx);
                    end
                end
            end
            default: ;   // unused code: ignored
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_request(cqd_pkg::t_cmd cmd, logic [31:0] w, logic typed,
                                cqd_pkg::t_status st, logic [31:0] v);
        int gap;
        t_result r;
        gap = sender_burst ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        queue_request(cmd, w);
        if (typed) begin
            r.status = st;
            r.word   = v;
            r.last   = 1'b1;
            awaited.push_back(r);
        end else begin
            foreach (fresh[i]) awaited.push_back(fresh[i]);
        end
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (awaited.size() != 0) @(posedge i_clk);
    endtask

    // size write only with the block idle
    task automatic write_size(int unsigned size);
        stop_sending();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= to_size(size);
        do @(posedge i_clk); while (!o_cfg_ready);
        set_size(to_size(size));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // result side: random stall before each result word
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = receiver_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result status %0d value %h last %b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                want = awaited.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata !== want.word) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.word, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last expected %b actual %b",
                             $time, want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- table
    function automatic t_row req_row(cqd_pkg::t_cmd cmd, logic [31:0] w);
        t_row r;
        r.is_cfg = 1'b0;
        r.size   = '0;
        r.cmd    = cmd;
        r.word   = w;
        r.typed  = 1'b0;
        r.status = cqd_pkg::ST_OK;
        r.value  = '0;
        return r;
    endfunction

    function automatic t_row typed_row(cqd_pkg::t_cmd cmd, logic [31:0] w,
                                       cqd_pkg::t_status st, logic [31:0] v);
        t_row r;
        r        = req_row(cmd, w);
        r.typed  = 1'b1;
        r.status = st;
        r.value  = v;
        return r;
    endfunction

    function automatic t_row cfg_row(int unsigned size);
        t_row r;
        r        = req_row(cqd_pkg::CMD_INSERT, '0);
        r.is_cfg = 1'b1;
        r.size   = to_size(size);
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus
    initial begin
        int unsigned   eff;
        int            len;
        int            ins_pct;
        int            roll;
        cqd_pkg::t_cmd cmd;
        errors         = 0;
        random_count   = 0;
        sender_burst   = 1'b0;
        receiver_burst = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = cqd_pkg::CMD_INSERT;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        foreach (slots[i]) slots[i] = '0;
        set_size(to_size(cqd_pkg::DEPTH));

        // after reset: empty, size DEPTH
        plan.push_back(typed_row(cqd_pkg::CMD_DELETE, '0, cqd_pkg::ST_EMPTY, '0));
        plan.push_back(typed_row(cqd_pkg::CMD_DUMP, '0, cqd_pkg::ST_EMPTY, '0));
        plan.push_back(typed_row(cqd_pkg::CMD_INSERT, 32'h7FFF_FFFF, cqd_pkg::ST_OK, '0));
        plan.push_back(typed_row(cqd_pkg::CMD_INSERT, 32'h8000_0000, cqd_pkg::ST_OK, '0));
        plan.push_back(req_row(CMD_UNUSED, 32'hDEAD_BEEF));
        plan.push_back(req_row(cqd_pkg::CMD_DUMP, '0));
        plan.push_back(typed_row(cqd_pkg::CMD_DELETE, '0, cqd_pkg::ST_OK, 32'h7FFF_FFFF));
        plan.push_back(typed_row(cqd_pkg::CMD_DELETE, '0, cqd_pkg::ST_OK, 32'h8000_0000));
        plan.push_back(typed_row(cqd_pkg::CMD_DELETE, '0, cqd_pkg::ST_EMPTY, '0));
        // one slot: full after a single word
        plan.push_back(cfg_row(1));
        plan.push_back(typed_row(cqd_pkg::CMD_INSERT, 32'hFFFF_FFFF, cqd_pkg::ST_OK, '0));
        plan.push_back(typed_row(cqd_pkg::CMD_INSERT, '0, cqd_pkg::ST_FULL, '0));
        plan.push_back(req_row(cqd_pkg::CMD_DUMP, '0));
        plan.push_back(typed_row(cqd_pkg::CMD_DELETE, '0, cqd_pkg::ST_OK, 32'hFFFF_FFFF));
        // zero acts as one
        plan.push_back(cfg_row(0));
        plan.push_back(typed_row(cqd_pkg::CMD_INSERT, 32'h1234_5678, cqd_pkg::ST_OK, '0));
        plan.push_back(typed_row(cqd_pkg::CMD_INSERT, 32'h0000_0001, cqd_pkg::ST_FULL, '0));
        // three slots: fill, wrap the tail, drain past the last word
        plan.push_back(cfg_row(3));
        plan.push_back(req_row(cqd_pkg::CMD_INSERT, 32'h0000_0011));
        plan.push_back(req_row(cqd_pkg::CMD_INSERT, 32'h0000_0022));
        plan.push_back(req_row(cqd_pkg::CMD_INSERT, 32'h0000_0033));
        plan.push_back(typed_row(cqd_pkg::CMD_INSERT, 32'h0000_0044, cqd_pkg::ST_FULL, '0));
        plan.push_back(req_row(cqd_pkg::CMD_DELETE, '0));
        plan.push_back(req_row(cqd_pkg::CMD_INSERT, 32'h0000_0055));
        plan.push_back(req_row(cqd_pkg::CMD_DUMP, '0));
        plan.push_back(req_row(cqd_pkg::CMD_DELETE, '0));
        plan.push_back(req_row(cqd_pkg::CMD_DELETE, '0));
        plan.push_back(req_row(cqd_pkg::CMD_DELETE, '0));
        plan.push_back(req_row(cqd_pkg::CMD_DUMP, '0));
        // above DEPTH acts as DEPTH
        plan.push_back(cfg_row(127));
        plan.push_back(req_row(cqd_pkg::CMD_INSERT, 32'h5A5A_A5A5));
        plan.push_back(req_row(cqd_pkg::CMD_DUMP, '0));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) write_size(plan[i].size);
            else send_request(plan[i].cmd, plan[i].word, plan[i].typed,
                              plan[i].status, plan[i].value);
        end

        // random phases, each under its own queue size
        while (random_count < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 9);
            case (roll)
                0, 1, 2, 3, 4, 5: write_size($urandom_range(1, 8));
                6:                write_size(0);
                7:                write_size($urandom_range(cqd_pkg::DEPTH, 127));
                8:                write_size($urandom_range(0, 127));
                default:          write_size($urandom_range(9, 32));
            endcase
            eff            = span();
            len            = (eff >= 32) ? 2 * eff + 20 : $urandom_range(20, 40);
            ins_pct        = (eff >= 32) ? 75 : 45;
            sender_burst   = ($urandom_range(0, 3) == 0);
            receiver_burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < len && random_count < RANDOM_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < ins_pct)               cmd = cqd_pkg::CMD_INSERT;
                else if (roll < ins_pct + 30)     cmd = cqd_pkg::CMD_DELETE;
                else if (roll < 95)               cmd = cqd_pkg::CMD_DUMP;
                else                              cmd = CMD_UNUSED;
                if (cmd == cqd_pkg::CMD_DUMP && $urandom_range(0, 2) != 0) begin
                    cmd = cqd_pkg::CMD_DELETE;
                end
                send_request(cmd, pick_word(), 1'b0, cqd_pkg::ST_OK, '0);
                random_count++;
                // hold the requests back until the result stream has caught up
                if ($urandom_range(0, 49) == 0) begin
                    stop_sending();
                    wait_drained();
                end
            end
        end

        stop_sending();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
